// ----- rtl/ppp_pkg.sv -----
package ppp_pkg;

    localparam int ACC_W      = 64;
    localparam int DIM_W      = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int COEF_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    localparam int OP_W = 3;
    typedef logic [OP_W-1:0] mac_op_t;

    localparam mac_op_t OP_NONE   = 3'd0;
    localparam mac_op_t OP_MUL_LO = 3'd1;
    localparam mac_op_t OP_MUL_HI = 3'd2;
    localparam mac_op_t OP_SUM    = 3'd3;
    localparam mac_op_t OP_ACC    = 3'd4;
    localparam mac_op_t OP_TRANS  = 3'd5;

    typedef struct packed {
        mac_op_t op;
        logic    first;
        logic    negate;
    } mac_ctrl_t;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

// ----- rtl/ppp_mac.sv -----
module ppp_mac #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  ppp_pkg::mac_ctrl_t                ctrl,
    input  logic signed [WORD_BITS-1:0]       a,
    input  logic signed [WORD_BITS-1:0]       b,
    output logic        [ppp_pkg::ACC_W-1:0]  acc,
    output logic signed [WORD_BITS-1:0]       vp
);

    localparam int LO_W  = (WORD_BITS + 1) / 2;
    localparam int MUL_W = WORD_BITS + LO_W + 1;
    localparam int SUM_W = 2 * WORD_BITS;
    localparam int BIG_W = (SUM_W > ppp_pkg::ACC_W) ? SUM_W : ppp_pkg::ACC_W + 1;
    localparam int VP_W  = SUM_W + 2;
    localparam int AW    = ppp_pkg::ACC_W;

    logic signed [LO_W:0]       op2;
    logic signed [MUL_W-1:0]    mres;
    logic signed [MUL_W-1:0]    plo_reg;
    logic signed [MUL_W-1:0]    phi_reg;
    logic signed [SUM_W-1:0]    full_reg;
    logic        [AW-1:0]       acc_reg;
    logic        [AW-1:0]       acc_next;
    logic signed [SUM_W-1:0]    sh;
    logic signed [BIG_W-1:0]    sh_big;
    logic        [AW-1:0]       prod_sat;
    logic        [AW-1:0]       addend;
    logic        [AW-1:0]       base;
    logic        [AW:0]         s_wide;
    logic signed [VP_W-1:0]     full_ext;
    logic signed [VP_W-1:0]     bias;
    logic signed [VP_W-1:0]     vt;

    // split multiply: low half unsigned, high half signed
    always_comb
    begin
        if (ctrl.op == ppp_pkg::OP_MUL_HI)
            op2 = (LO_W+1)'(signed'(b[WORD_BITS-1:LO_W]));
        else
            op2 = signed'({1'b0, b[LO_W-1:0]});
    end

    assign mres = MUL_W'(a) * MUL_W'(op2);

    // floor shift, saturate, then saturating accumulate
    assign sh       = full_reg >>> FRAC_BITS;
    assign sh_big   = BIG_W'(sh);
    assign prod_sat = (&sh_big[BIG_W-1:AW-1] || ~|sh_big[BIG_W-1:AW-1]) ? sh_big[AW-1:0] :
                      (sh_big[BIG_W-1] ? ppp_pkg::ACC_MIN : ppp_pkg::ACC_MAX);
    assign addend   = (ctrl.op == ppp_pkg::OP_TRANS) ? AW'(b) : prod_sat;
    assign base     = ctrl.first ? '0 : acc_reg;
    assign s_wide   = {base[AW-1], base} + {addend[AW-1], addend};
    assign acc_next = (s_wide[AW] == s_wide[AW-1]) ? s_wide[AW-1:0] :
                      (s_wide[AW] ? ppp_pkg::ACC_MIN : ppp_pkg::ACC_MAX);

    // viewport: +/- product plus half size, saturated to a word
    assign full_ext = VP_W'(full_reg);
    assign bias     = VP_W'(b) <<< FRAC_BITS;
    assign vt       = (ctrl.negate ? -full_ext : full_ext) + bias;
    assign vp       = (&vt[VP_W-1:WORD_BITS-1] || ~|vt[VP_W-1:WORD_BITS-1]) ?
                      vt[WORD_BITS-1:0] :
                      (vt[VP_W-1] ? {1'b1, {(WORD_BITS-1){1'b0}}} :
                                    {1'b0, {(WORD_BITS-1){1'b1}}});

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            ppp_pkg::OP_MUL_LO: plo_reg  <= mres;
            ppp_pkg::OP_MUL_HI: phi_reg  <= mres;
            ppp_pkg::OP_SUM:    full_reg <= (SUM_W'(phi_reg) <<< LO_W) + SUM_W'(plo_reg);
            ppp_pkg::OP_ACC,
            ppp_pkg::OP_TRANS:  acc_reg  <= acc_next;
            default:
            begin
            end
        endcase
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/ppp_div.sv -----
module ppp_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic        [ppp_pkg::ACC_W-1:0]  num,
    input  logic        [ppp_pkg::ACC_W-1:0]  den,
    output logic                              busy,
    output logic                              done,
    output logic signed [WORD_BITS-1:0]       quot
);

    localparam int AW    = ppp_pkg::ACC_W;
    localparam int NUM_W = AW + FRAC_BITS;
    localparam int REM_W = AW + 2;
    localparam int Q_W   = WORD_BITS - 1;
    localparam int CNT_W = $clog2(WORD_BITS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] den_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   q_reg;
    logic             neg_reg;
    logic             ovf_reg;

    logic             neg_in;
    logic [AW-1:0]    mag_in;
    logic [NUM_W-1:0] n_full;
    logic [REM_W-1:0] rem_init;
    logic [REM_W-1:0] den_ext;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign neg_in   = num[AW-1];
    assign mag_in   = neg_in ? -num : num;
    assign n_full   = {mag_in, {FRAC_BITS{1'b0}}};
    assign rem_init = REM_W'(n_full >> (WORD_BITS - 1));
    assign den_ext  = REM_W'(den);
    assign trial    = {rem_reg[REM_W-2:0], low_reg[Q_W-1]};
    assign fits     = trial >= den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            low_reg <= n_full[Q_W-1:0];
            den_reg <= den_ext;
            neg_reg <= neg_in;
            ovf_reg <= rem_init >= den_ext;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial - den_reg : trial;
            low_reg <= low_reg << 1;
            q_reg   <= {q_reg[Q_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = ovf_reg ? (neg_reg ? {1'b1, {Q_W{1'b0}}} : {1'b0, {Q_W{1'b1}}}) :
                  (neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg});

endmodule

// ----- rtl/perspective_point_projector.sv -----
// perspective point projector
// input channel: in_valid / in_stall with command, coef_index, coef_value, pos_x/y/z
// a load request writes one column-major matrix coefficient and gives no result
// a project request gives one result on out_valid / out_stall: visible, screen_x, screen_y
// cfg_write / cfg_index / cfg_data set viewport width (index 0) and height (index 1)
// one request at a time: in_stall is high from acceptance of a project request
// until its result sits in the output register
// three matrix rows are computed on one shared split multiplier
// (two half products, a sum, an accumulate per term, plus the translation term),
// then two restoring divisions run on one subtract unit,
// then the viewport mapping runs on the same multiplier
// a point whose clip w is below the threshold finishes after the w row, not visible, at 0, 0
// a load request is written at acceptance and leaves the input free for the next request
// a stalled result holds in the output register; a finished project request
// waits for it to drain before it is loaded
// reset: matrix all zero, width 1024, height 768, no result pending
module perspective_point_projector #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic        [ppp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [ppp_pkg::DIM_W-1:0]       cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   command,
    input  logic        [ppp_pkg::COEF_IDX_W-1:0]  coef_index,
    input  logic signed [WORD_BITS-1:0]            coef_value,
    input  logic signed [WORD_BITS-1:0]            pos_x,
    input  logic signed [WORD_BITS-1:0]            pos_y,
    input  logic signed [WORD_BITS-1:0]            pos_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   visible,
    output logic signed [WORD_BITS-1:0]            screen_x,
    output logic signed [WORD_BITS-1:0]            screen_y
);

    localparam int AW = ppp_pkg::ACC_W;
    localparam logic [AW-1:0] W_THRESH = ((64'd1 << FRAC_BITS) + 64'd9) / 64'd10;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_VIEW = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                     state_reg;
    logic [1:0]                     row_reg;
    logic [1:0]                     term_reg;
    logic [1:0]                     phase_reg;
    logic                           sel_reg;
    logic                           out_valid_reg;
    logic [ppp_pkg::DIM_W-1:0]      width_reg;
    logic [ppp_pkg::DIM_W-1:0]      height_reg;
    logic signed [WORD_BITS-1:0]    coef_reg [16];

    logic signed [WORD_BITS-1:0]    px_reg;
    logic signed [WORD_BITS-1:0]    py_reg;
    logic signed [WORD_BITS-1:0]    pz_reg;
    logic [AW-1:0]                  cw_reg;
    logic [AW-1:0]                  cx_reg;
    logic [AW-1:0]                  cy_reg;
    logic signed [WORD_BITS-1:0]    nx_reg;
    logic signed [WORD_BITS-1:0]    ny_reg;
    logic                           vis_reg;
    logic signed [WORD_BITS-1:0]    sx_reg;
    logic signed [WORD_BITS-1:0]    sy_reg;
    logic                           out_vis_reg;
    logic signed [WORD_BITS-1:0]    out_x_reg;
    logic signed [WORD_BITS-1:0]    out_y_reg;

    logic [1:0]                     mat_row;
    logic [ppp_pkg::COEF_IDX_W-1:0] coef_addr;
    logic signed [WORD_BITS-1:0]    coef_rd;
    logic signed [WORD_BITS-1:0]    half_w;
    logic signed [WORD_BITS-1:0]    half_h;
    ppp_pkg::mac_ctrl_t             mac_ctrl;
    logic signed [WORD_BITS-1:0]    mac_a;
    logic signed [WORD_BITS-1:0]    mac_b;
    logic [AW-1:0]                  acc;
    logic signed [WORD_BITS-1:0]    vp;
    logic                           div_start;
    logic                           div_busy;
    logic                           div_done;
    logic signed [WORD_BITS-1:0]    quot;

    logic                           accept_in;
    logic                           cap_row;
    logic                           w_low;
    logic                           vp_take;
    logic                           done_go;

    // row order w, x, y maps to matrix rows 3, 0, 1
    assign mat_row   = row_reg + 2'd3;
    assign coef_addr = {term_reg, mat_row};
    assign coef_rd   = coef_reg[coef_addr];
    assign half_w    = WORD_BITS'(width_reg[ppp_pkg::DIM_W-1:1]);
    assign half_h    = WORD_BITS'(height_reg[ppp_pkg::DIM_W-1:1]);

    assign accept_in = in_valid && (state_reg == ST_IDLE);
    assign cap_row   = (state_reg == ST_MAC) && (term_reg == 2'd3) && (phase_reg == 2'd1);
    assign w_low     = acc[AW-1] || (acc < W_THRESH);
    assign vp_take   = (state_reg == ST_VIEW) && (phase_reg == 2'd3);
    assign done_go   = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign div_start = (state_reg == ST_DIV) && (phase_reg == 2'd0);

    always_comb
    begin
        mac_ctrl.op     = ppp_pkg::OP_NONE;
        mac_ctrl.first  = 1'b0;
        mac_ctrl.negate = sel_reg;
        if (state_reg == ST_MAC)
        begin
            if (term_reg != 2'd3)
            begin
                unique case (phase_reg)
                    2'd0: mac_ctrl.op = ppp_pkg::OP_MUL_LO;
                    2'd1: mac_ctrl.op = ppp_pkg::OP_MUL_HI;
                    2'd2: mac_ctrl.op = ppp_pkg::OP_SUM;
                    2'd3: mac_ctrl.op = ppp_pkg::OP_ACC;
                endcase
                mac_ctrl.first = (term_reg == 2'd0);
            end
            else if (phase_reg == 2'd0)
                mac_ctrl.op = ppp_pkg::OP_TRANS;
        end
        else if (state_reg == ST_VIEW)
        begin
            unique case (phase_reg)
                2'd0: mac_ctrl.op = ppp_pkg::OP_MUL_LO;
                2'd1: mac_ctrl.op = ppp_pkg::OP_MUL_HI;
                2'd2: mac_ctrl.op = ppp_pkg::OP_SUM;
                2'd3: mac_ctrl.op = ppp_pkg::OP_NONE;
            endcase
        end
    end

    always_comb
    begin
        if (state_reg == ST_VIEW)
        begin
            mac_a = sel_reg ? ny_reg : nx_reg;
            mac_b = sel_reg ? half_h : half_w;
        end
        else
        begin
            priority if (term_reg == 2'd0)
                mac_a = px_reg;
            else if (term_reg == 2'd1)
                mac_a = py_reg;
            else
                mac_a = pz_reg;
            mac_b = coef_rd;
        end
    end

    ppp_mac #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (acc),
        .vp   (vp)
    );

    ppp_div #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sel_reg ? cy_reg : cx_reg),
        .den   (cw_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= 2'd0;
            term_reg      <= 2'd0;
            phase_reg     <= 2'd0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= ppp_pkg::DIM_W'(1024);
            height_reg    <= ppp_pkg::DIM_W'(768);
            for (int i = 0; i < 16; i++)
                coef_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ppp_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    ppp_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                endcase
            end

            if (done_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        if (command == ppp_pkg::CMD_LOAD)
                            coef_reg[coef_index] <= coef_value;
                        else
                        begin
                            state_reg <= ST_MAC;
                            row_reg   <= 2'd0;
                            term_reg  <= 2'd0;
                            phase_reg <= 2'd0;
                        end
                    end
                end
                ST_MAC:
                begin
                    if (term_reg != 2'd3)
                    begin
                        phase_reg <= phase_reg + 2'd1;
                        if (phase_reg == 2'd3)
                            term_reg <= term_reg + 2'd1;
                    end
                    else if (phase_reg == 2'd0)
                        phase_reg <= 2'd1;
                    else
                    begin
                        phase_reg <= 2'd0;
                        term_reg  <= 2'd0;
                        if (row_reg == 2'd0 && w_low)
                            state_reg <= ST_DONE;
                        else if (row_reg == 2'd2)
                        begin
                            state_reg <= ST_DIV;
                            sel_reg   <= 1'b0;
                        end
                        else
                            row_reg <= row_reg + 2'd1;
                    end
                end
                ST_DIV:
                begin
                    if (phase_reg == 2'd0)
                        phase_reg <= 2'd1;
                    else if (div_done)
                    begin
                        phase_reg <= 2'd0;
                        if (sel_reg)
                        begin
                            state_reg <= ST_VIEW;
                            sel_reg   <= 1'b0;
                        end
                        else
                            sel_reg <= 1'b1;
                    end
                end
                ST_VIEW:
                begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd3)
                    begin
                        if (sel_reg)
                            state_reg <= ST_DONE;
                        else
                            sel_reg <= 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (done_go)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in && command == ppp_pkg::CMD_PROJECT)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end
        if (cap_row)
        begin
            unique case (row_reg)
                2'd0:    cw_reg <= acc;
                2'd1:    cx_reg <= acc;
                default: cy_reg <= acc;
            endcase
            if (row_reg == 2'd0 && w_low)
            begin
                vis_reg <= 1'b0;
                sx_reg  <= '0;
                sy_reg  <= '0;
            end
        end
        if (div_done)
        begin
            if (sel_reg)
                ny_reg <= quot;
            else
                nx_reg <= quot;
        end
        if (vp_take)
        begin
            vis_reg <= 1'b1;
            if (sel_reg)
                sy_reg <= vp;
            else
                sx_reg <= vp;
        end
        if (done_go)
        begin
            out_vis_reg <= vis_reg;
            out_x_reg   <= sx_reg;
            out_y_reg   <= sy_reg;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign visible   = out_vis_reg;
    assign screen_x  = out_x_reg;
    assign screen_y  = out_y_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && command == ppp_pkg::CMD_PROJECT) |=> in_stall)
        else $error("project request did not hold off the input");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && command == ppp_pkg::CMD_LOAD && !out_valid_reg) |=> !out_valid_reg)
        else $error("load request produced a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_vis_reg) |-> (out_x_reg == '0 && out_y_reg == '0))
        else $error("hidden point with nonzero coordinates");

endmodule
